// ----- rtl/bhs_pkg.sv -----
package bhs_pkg;

    localparam int BLOCK_COUNT_DEF     = 64;
    localparam int MAX_LINE_BLOCKS_DEF = 15;
    localparam int MAX_ENTRIES_DEF     = 64;
    localparam int MAX_LINE_BYTES_DEF  = 120;

    localparam int CMD_W   = 2;
    localparam int CHUNK_W = 64;
    localparam int LEN_W   = 7;
    localparam int AGE_W   = 6;
    localparam int DEL_W   = 7;
    localparam int TOTAL_W = 4;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - CHUNK_W - TOTAL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_GET    = 2'd1,
        CMD_DELETE = 2'd2
    } bhs_cmd_t;

    typedef enum logic [1:0] {
        EMIT_OK   = 2'd0,
        EMIT_FAIL = 2'd1,
        EMIT_DATA = 2'd2
    } bhs_emit_t;

    typedef struct packed {
        logic      load;
        logic      rel_start_oldest;
        logic      rel_start_youngest;
        logic      rel_clear;
        logic      rel_done_evict;
        logic      rel_done_delete;
        logic      alloc_start;
        logic      alloc_step;
        logic      alloc_end;
        logic      wr_chunk;
        logic      idx_inc;
        logic      emit;
        bhs_emit_t emit_kind;
    } bhs_ctl_t;

    typedef struct packed {
        logic fill_zero;
        logic evict_needed;
        logic entries_empty;
        logic age_miss;
        logic del_zero;
        logic rel_more;
        logic size_zero;
        logic alloc_done;
        logic out_free;
        logic data_last;
    } bhs_sts_t;

endpackage

// ----- rtl/bhs_ctrl.sv -----
module bhs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bhs_pkg::CMD_W-1:0] in_cmd,
    input  bhs_pkg::bhs_sts_t         sts,
    output bhs_pkg::bhs_ctl_t         ctl
);
    import bhs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_CHK,
        S_REL_SZ,
        S_REL_LP,
        S_REL_CLR,
        S_ALLOC,
        S_ALLOC_END,
        S_WR_RD,
        S_WR_WR,
        S_GET_CHK,
        S_GET_SZ,
        S_GET_IDX,
        S_GET_BLK,
        S_GET_EMIT,
        S_DEL_CHK
    } state_t;

    state_t state_reg, state_next;
    logic   del_mode_reg, del_mode_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl           = '0;
        ctl.emit_kind = EMIT_OK;
        state_next    = state_reg;
        del_mode_next = del_mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.load = 1'b1;
                    case (bhs_cmd_t'(in_cmd))
                        CMD_INSERT:
                        begin
                            del_mode_next = 1'b0;
                            state_next    = sts.fill_zero ? S_EV_CHK : S_WR_RD;
                        end
                        CMD_GET:
                        begin
                            state_next = S_GET_CHK;
                        end
                        CMD_DELETE:
                        begin
                            del_mode_next = 1'b1;
                            state_next    = S_DEL_CHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EV_CHK:
            begin
                if (sts.evict_needed)
                begin
                    ctl.rel_start_oldest = 1'b1;
                    state_next           = S_REL_SZ;
                end
                else
                begin
                    ctl.alloc_start = 1'b1;
                    state_next      = S_ALLOC;
                end
            end
            S_REL_SZ:
            begin
                state_next = S_REL_LP;
            end
            S_REL_LP:
            begin
                if (sts.rel_more)
                begin
                    state_next = S_REL_CLR;
                end
                else if (del_mode_reg)
                begin
                    ctl.rel_done_delete = 1'b1;
                    state_next          = S_DEL_CHK;
                end
                else
                begin
                    ctl.rel_done_evict = 1'b1;
                    state_next         = S_EV_CHK;
                end
            end
            S_REL_CLR:
            begin
                ctl.rel_clear = 1'b1;
                state_next    = S_REL_LP;
            end
            S_ALLOC:
            begin
                if (sts.alloc_done)
                begin
                    state_next = S_ALLOC_END;
                end
                else
                begin
                    ctl.alloc_step = 1'b1;
                end
            end
            S_ALLOC_END:
            begin
                ctl.alloc_end = 1'b1;
                state_next    = S_IDLE;
            end
            S_WR_RD:
            begin
                state_next = S_WR_WR;
            end
            S_WR_WR:
            begin
                ctl.wr_chunk = 1'b1;
                state_next   = S_IDLE;
            end
            S_GET_CHK:
            begin
                if (!sts.age_miss)
                begin
                    state_next = S_GET_SZ;
                end
                else if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = EMIT_FAIL;
                    state_next    = S_IDLE;
                end
            end
            S_GET_SZ:
            begin
                if (!sts.size_zero)
                begin
                    state_next = S_GET_BLK;
                end
                else if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = EMIT_OK;
                    state_next    = S_IDLE;
                end
            end
            S_GET_IDX:
            begin
                state_next = S_GET_BLK;
            end
            S_GET_BLK:
            begin
                state_next = S_GET_EMIT;
            end
            S_GET_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = EMIT_DATA;
                    if (sts.data_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        state_next  = S_GET_IDX;
                    end
                end
            end
            S_DEL_CHK:
            begin
                if (sts.del_zero || sts.entries_empty)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit      = 1'b1;
                        ctl.emit_kind = sts.del_zero ? EMIT_OK : EMIT_FAIL;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    ctl.rel_start_youngest = 1'b1;
                    state_next             = S_REL_SZ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            del_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            del_mode_reg <= del_mode_next;
        end
    end

endmodule

// ----- rtl/bhs_dp.sv -----
module bhs_dp #(
    parameter int BLOCK_COUNT     = bhs_pkg::BLOCK_COUNT_DEF,
    parameter int MAX_LINE_BLOCKS = bhs_pkg::MAX_LINE_BLOCKS_DEF,
    parameter int MAX_ENTRIES     = bhs_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_LINE_BYTES  = bhs_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bhs_pkg::bhs_ctl_t           ctl,
    output bhs_pkg::bhs_sts_t           sts,
    input  logic [bhs_pkg::CMD_W-1:0]   in_cmd,
    input  logic [bhs_pkg::CHUNK_W-1:0] chunk,
    input  logic [bhs_pkg::LEN_W-1:0]   line_length,
    input  logic                        chunk_last,
    input  logic [bhs_pkg::AGE_W-1:0]   entry_age,
    input  logic [bhs_pkg::DEL_W-1:0]   delete_count,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic                        status,
    output logic [bhs_pkg::CHUNK_W-1:0] data_chunk,
    output logic [bhs_pkg::TOTAL_W-1:0] block_total,
    output logic                        last
);
    import bhs_pkg::*;

    localparam int BW  = $clog2(BLOCK_COUNT);
    localparam int SCW = $clog2(BLOCK_COUNT + 1);
    localparam int SW  = $clog2(MAX_ENTRIES);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int PW  = $clog2(MAX_LINE_BLOCKS + 1);
    localparam int IW  = (MAX_LINE_BLOCKS > 1) ? $clog2(MAX_LINE_BLOCKS) : 1;
    localparam int EB_DEPTH = MAX_ENTRIES * (2 ** IW);
    localparam int TXW = PW + TOTAL_W;

    function automatic logic [SW-1:0] slot_back(input int y, input int d);
        int t;
        t = y - d;
        if (t < 0)
        begin
            t = t + MAX_ENTRIES;
        end
        return SW'(t);
    endfunction

    logic [BLOCK_COUNT-1:0] free_map_reg;
    logic [SCW-1:0]         free_count_reg;
    logic [SW-1:0]          youngest_reg;
    logic [ECW-1:0]         entry_count_reg;
    logic [PW-1:0]          fill_reg;
    logic                   out_valid_reg;

    logic [CHUNK_W-1:0]     chunk_reg;
    logic                   last_reg;
    logic [AGE_W-1:0]       age_reg;
    logic [DEL_W-1:0]       del_reg;
    logic [PW-1:0]          nb_reg;
    logic [SW-1:0]          slot_reg;
    logic [PW-1:0]          idx_reg;
    logic [SCW-1:0]         scan_reg;
    logic [PW-1:0]          line_size_reg;
    logic                   status_reg;
    logic [CHUNK_W-1:0]     data_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   last_out_reg;

    logic [CHUNK_W-1:0]     bmem [BLOCK_COUNT];
    logic [PW-1:0]          esz  [MAX_ENTRIES];
    logic [BW-1:0]          eblk [EB_DEPTH];
    logic [CHUNK_W-1:0]     bmem_q;
    logic [PW-1:0]          esz_q;
    logic [BW-1:0]          eblk_q;

    logic [SW+IW-1:0]       eb_addr;
    logic                   scan_free;
    logic                   bm_we;
    logic [BW-1:0]          bm_waddr;
    logic [CHUNK_W-1:0]     bm_wdata;
    logic [PW-1:0]          nb_calc;
    logic [SW-1:0]          slot_next_young;
    logic [SW-1:0]          slot_prev_young;
    logic [PW-1:0]          idx_plus;
    logic [TXW-1:0]         total_ext;
    bhs_cmd_t               cmd;

    assign cmd             = bhs_cmd_t'(in_cmd);
    assign eb_addr         = {slot_reg, idx_reg[IW-1:0]};
    assign scan_free       = !free_map_reg[scan_reg[BW-1:0]];
    assign idx_plus        = idx_reg + PW'(1);
    assign total_ext       = TXW'(esz_q);
    assign slot_next_young = (int'(youngest_reg) == MAX_ENTRIES - 1) ? '0 : youngest_reg + SW'(1);
    assign slot_prev_young = (youngest_reg == '0) ? SW'(MAX_ENTRIES - 1) : youngest_reg - SW'(1);

    always_comb
    begin
        int len;
        int nb;
        len = int'(line_length);
        if (len > MAX_LINE_BYTES)
        begin
            len = MAX_LINE_BYTES;
        end
        nb = (len + 7) >> 3;
        if (nb > MAX_LINE_BLOCKS)
        begin
            nb = MAX_LINE_BLOCKS;
        end
        if (nb > BLOCK_COUNT)
        begin
            nb = BLOCK_COUNT;
        end
        nb_calc = PW'(nb);
    end

    always_comb
    begin
        sts.fill_zero     = (fill_reg == '0);
        sts.evict_needed  = ((int'(free_count_reg) < int'(nb_reg))
                             || (int'(entry_count_reg) >= MAX_ENTRIES))
                            && (entry_count_reg != '0);
        sts.entries_empty = (entry_count_reg == '0);
        sts.age_miss      = (int'(age_reg) >= int'(entry_count_reg));
        sts.del_zero      = (del_reg == '0);
        sts.rel_more      = (idx_reg != esz_q);
        sts.size_zero     = (esz_q == '0);
        sts.alloc_done    = (idx_reg == nb_reg) || (int'(scan_reg) >= BLOCK_COUNT);
        sts.out_free      = !out_valid_reg || m_tready;
        sts.data_last     = (idx_plus == esz_q);
    end

    always_comb
    begin
        bm_we    = 1'b0;
        bm_waddr = eblk_q;
        bm_wdata = chunk_reg;
        if (ctl.alloc_step && scan_free)
        begin
            bm_we    = 1'b1;
            bm_waddr = scan_reg[BW-1:0];
            bm_wdata = (idx_reg == '0) ? chunk_reg : '0;
        end
        else if (ctl.wr_chunk)
        begin
            bm_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        esz_q  <= esz[slot_reg];
        eblk_q <= eblk[eb_addr];
        bmem_q <= bmem[eblk_q];
        if (ctl.alloc_end)
        begin
            esz[slot_reg] <= idx_reg;
        end
        if (ctl.alloc_step && scan_free)
        begin
            eblk[eb_addr] <= scan_reg[BW-1:0];
        end
        if (bm_we)
        begin
            bmem[bm_waddr] <= bm_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg    <= '0;
            free_count_reg  <= SCW'(BLOCK_COUNT);
            youngest_reg    <= '0;
            entry_count_reg <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.load && (cmd == CMD_GET || cmd == CMD_DELETE))
            begin
                fill_reg <= '0;
            end
            if (ctl.rel_clear)
            begin
                free_map_reg[eblk_q] <= 1'b0;
                free_count_reg       <= free_count_reg + SCW'(1);
            end
            if (ctl.rel_done_evict)
            begin
                entry_count_reg <= entry_count_reg - ECW'(1);
            end
            if (ctl.rel_done_delete)
            begin
                entry_count_reg <= entry_count_reg - ECW'(1);
                youngest_reg    <= slot_prev_young;
            end
            if (ctl.alloc_step && scan_free)
            begin
                free_map_reg[scan_reg[BW-1:0]] <= 1'b1;
                free_count_reg                 <= free_count_reg - SCW'(1);
            end
            if (ctl.alloc_end)
            begin
                youngest_reg    <= slot_reg;
                entry_count_reg <= entry_count_reg + ECW'(1);
                fill_reg        <= (idx_reg > PW'(1) && !last_reg) ? PW'(1) : '0;
            end
            if (ctl.wr_chunk)
            begin
                fill_reg <= (last_reg || idx_plus >= line_size_reg) ? '0 : idx_plus;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            chunk_reg <= chunk;
            last_reg  <= chunk_last;
            age_reg   <= entry_age;
            del_reg   <= delete_count;
            nb_reg    <= nb_calc;
            slot_reg  <= (cmd == CMD_GET) ? slot_back(int'(youngest_reg), int'(entry_age))
                                          : youngest_reg;
            idx_reg   <= (cmd == CMD_INSERT) ? fill_reg : '0;
        end
        if (ctl.rel_start_oldest)
        begin
            slot_reg <= slot_back(int'(youngest_reg), int'(entry_count_reg) - 1);
            idx_reg  <= '0;
        end
        if (ctl.rel_start_youngest)
        begin
            slot_reg <= youngest_reg;
            idx_reg  <= '0;
        end
        if (ctl.rel_clear || ctl.idx_inc || (ctl.alloc_step && scan_free))
        begin
            idx_reg <= idx_plus;
        end
        if (ctl.rel_done_delete)
        begin
            del_reg <= del_reg - DEL_W'(1);
        end
        if (ctl.alloc_start)
        begin
            slot_reg <= slot_next_young;
            idx_reg  <= '0;
            scan_reg <= '0;
        end
        if (ctl.alloc_step)
        begin
            scan_reg <= scan_reg + SCW'(1);
        end
        if (ctl.alloc_end)
        begin
            line_size_reg <= idx_reg;
        end
        if (ctl.emit)
        begin
            case (ctl.emit_kind)
                EMIT_DATA:
                begin
                    status_reg   <= 1'b0;
                    data_reg     <= bmem_q;
                    total_reg    <= total_ext[TOTAL_W-1:0];
                    last_out_reg <= sts.data_last;
                end
                EMIT_FAIL:
                begin
                    status_reg   <= 1'b1;
                    data_reg     <= '0;
                    total_reg    <= '0;
                    last_out_reg <= 1'b1;
                end
                default:
                begin
                    status_reg   <= 1'b0;
                    data_reg     <= '0;
                    total_reg    <= '0;
                    last_out_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign status      = status_reg;
    assign data_chunk  = data_reg;
    assign block_total = total_reg;
    assign last        = last_out_reg;

endmodule

// ----- rtl/block_history_store.sv -----
// Line history store: lines of up to MAX_LINE_BYTES bytes are kept as 8-byte
// blocks in a BLOCK_COUNT-block memory, found by scanning a free map from the
// lowest index one block per cycle. An insert line arrives as chunks with
// tuser = insert; the first chunk evicts oldest entries, one freed block at a
// time, then scans the free map and stores the chunk; later chunks give no
// result. A get returns its items in order through the chained index, block
// and output register reads, each waiting for a free output register. A
// delete frees the youngest entries at the same cost as eviction and returns
// one item. The block takes one item at a time; a final result waits in the
// output register while the next item is accepted.
module block_history_store #(
    parameter int BLOCK_COUNT     = bhs_pkg::BLOCK_COUNT_DEF,
    parameter int MAX_LINE_BLOCKS = bhs_pkg::MAX_LINE_BLOCKS_DEF,
    parameter int MAX_ENTRIES     = bhs_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_LINE_BYTES  = bhs_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // chunk, line_length, entry_age, delete_count
    input  logic [bhs_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [bhs_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_chunk, block_total
    output logic [bhs_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import bhs_pkg::*;

    bhs_ctl_t             ctl;
    bhs_sts_t             sts;
    logic [CHUNK_W-1:0]   data_chunk;
    logic [TOTAL_W-1:0]   block_total;

    bhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .sts      (sts),
        .ctl      (ctl)
    );

    bhs_dp #(
        .BLOCK_COUNT     (BLOCK_COUNT),
        .MAX_LINE_BLOCKS (MAX_LINE_BLOCKS),
        .MAX_ENTRIES     (MAX_ENTRIES),
        .MAX_LINE_BYTES  (MAX_LINE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .in_cmd       (s_tuser),
        .chunk        (s_tdata[CHUNK_W-1:0]),
        .line_length  (s_tdata[CHUNK_W+LEN_W-1:CHUNK_W]),
        .chunk_last   (s_tlast),
        .entry_age    (s_tdata[CHUNK_W+LEN_W+AGE_W-1:CHUNK_W+LEN_W]),
        .delete_count (s_tdata[CHUNK_W+LEN_W+AGE_W+DEL_W-1:CHUNK_W+LEN_W+AGE_W]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .status       (m_tuser),
        .data_chunk   (data_chunk),
        .block_total  (block_total),
        .last         (m_tlast)
    );

    assign m_tdata = {M_PAD_W'(0), block_total, data_chunk};

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> sts.out_free)
        else $error("result issued over a pending result");

    a_ops_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.rel_clear, ctl.alloc_step, ctl.alloc_end,
                  ctl.wr_chunk, ctl.emit}))
        else $error("datapath operations overlap");

    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc_step |-> !sts.alloc_done)
        else $error("allocation step past its end");

endmodule

// ----- verif/tb_block_history_store.sv -----
`timescale 1ns / 1ps

module tb_block_history_store;
    import bhs_pkg::*;

    localparam int NBLK = 64;
    localparam int NLB  = 15;
    localparam int NENT = 64;
    localparam int NBYT = 120;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic        status;
        logic [63:0] data;
        logic [3:0]  total;
        logic        last;
    } reply_t;

    typedef struct {
        bhs_cmd_t    cmd;
        logic [63:0] chunk;
        logic [6:0]  len;
        logic        clast;
        logic [5:0]  age;
        logic [6:0]  dcount;
        logic        known;
        reply_t      want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    always #2 clk = ~clk;

    block_history_store dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    logic        used_map [NBLK];
    int          free_blocks;
    logic [63:0] blk_mem [NBLK];
    int          slot_size [NENT];
    int          slot_blk [NENT][NLB];
    int          newest;
    int          live_entries;
    int          fill_pos;

    reply_t replies_due [$];
    int     mismatches = 0;
    bit     hold_off = 1'b0;

    function automatic int age_slot(int a);
        return (newest + NENT - (a % NENT)) % NENT;
    endfunction

    function automatic void free_slot(int s);
        for (int i = 0; i < slot_size[s] && i < NLB; i++) begin
            if (used_map[slot_blk[s][i]])
            begin
                used_map[slot_blk[s][i]] = 1'b0;
                free_blocks++;
            end
        end
        slot_size[s] = 0;
    endfunction

    function automatic void open_line(int len);
        int nb;
        int s;
        int got;
        if (len > NBYT) len = NBYT;
        nb = (len + 7) / 8;
        if (nb > NLB) nb = NLB;
        while ((free_blocks < nb || live_entries >= NENT) && live_entries > 0)
        begin
            free_slot(age_slot(live_entries - 1));
            live_entries--;
        end
        s = (newest + 1) % NENT;
        got = 0;
        for (int i = 0; i < NBLK && got < nb; i++) begin
            if (!used_map[i])
            begin
                used_map[i] = 1'b1;
                free_blocks--;
                blk_mem[i] = '0;
                slot_blk[s][got] = i;
                got++;
            end
        end
        slot_size[s] = got;
        newest = s;
        live_entries++;
    endfunction

    function automatic void store_reset();
        for (int i = 0; i < NBLK; i++) begin used_map[i] = 0; blk_mem[i] = '0; end
        for (int i = 0; i < NENT; i++) slot_size[i] = 0;
        free_blocks = NBLK;
        newest = 0;
        live_entries = 0;
        fill_pos = 0;
    endfunction

    function automatic void predict_store(row_t r);
        int pos;
        int sz;
        int s;
        int n;
        reply_t q;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (fill_pos == 0)
                begin
                    open_line(r.len);
                    pos = 0;
                end
                else pos = fill_pos;
                sz = slot_size[newest];
                if (pos >= sz)
                    fill_pos = 0;
                else
                begin
                    blk_mem[slot_blk[newest][pos]] = r.chunk;
                    pos++;
                    fill_pos = (r.clast || pos >= sz) ? 0 : pos;
                end
            end
            CMD_GET:
            begin
                fill_pos = 0;
                if (r.age >= live_entries)
                begin
                    q = '{1'b1, 64'd0, 4'd0, 1'b1};
                    replies_due.push_back(q);
                end
                else
                begin
                    s = age_slot(r.age);
                    sz = slot_size[s];
                    if (sz == 0)
                    begin
                        q = '{1'b0, 64'd0, 4'd0, 1'b1};
                        replies_due.push_back(q);
                    end
                    for (int i = 0; i < sz; i++) begin
                        q = '{1'b0, blk_mem[slot_blk[s][i]], 4'(sz), i + 1 == sz};
                        replies_due.push_back(q);
                    end
                end
            end
            CMD_DELETE:
            begin
                fill_pos = 0;
                q = '{1'b0, 64'd0, 4'd0, 1'b1};
                n = r.dcount;
                while (n > 0) begin
                    if (live_entries == 0)
                    begin
                        q.status = 1'b1;
                        break;
                    end
                    free_slot(newest);
                    newest = (newest + NENT - 1) % NENT;
                    live_entries--;
                    n--;
                end
                replies_due.push_back(q);
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(row_t r);
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (r.known)
        begin
            predict_store(r);
            if (r.cmd != CMD_INSERT)
            begin
                void'(replies_due.pop_back());
                replies_due.push_back(r.want);
            end
        end
        else predict_store(r);
        s_tdata  <= S_TDATA_W'({r.dcount, r.age, r.len, r.chunk});
        s_tuser  <= r.cmd;
        s_tlast  <= r.clast;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic row_t mk(bhs_cmd_t c, logic [63:0] ch, int len, bit cl,
                                int age, int dc);
        row_t r;
        r.cmd = c; r.chunk = ch; r.len = 7'(len); r.clast = cl;
        r.age = 6'(age); r.dcount = 7'(dc); r.known = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t mkw(bhs_cmd_t c, int age, int dc, bit st);
        row_t r;
        r = mk(c, '0, 0, 0, age, dc);
        r.known = 1'b1;
        r.want = '{st, 64'd0, 4'd0, 1'b1};
        return r;
    endfunction

    always @(posedge clk) begin
        reply_t got;
        reply_t exp_r;
        if (m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[63:0], m_tdata[67:64], m_tlast};
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", got);
            end
            else
            begin
                exp_r = replies_due.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", exp_r, got);
                end
            end
        end
    end

    initial begin
        int n;
        @(negedge clk);
        forever begin
            if (hold_off)
                m_tready <= 1'b0;
            else
            begin
                n = $urandom_range(0, 9);
                m_tready <= (n < 6) || ($urandom_range(0, 1) == 0 && n < 8);
            end
            @(negedge clk);
        end
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        row_t rows [$];
        row_t r;
        int len;
        int nb;
        int pick;
        int wait_c;
        bit pressed;
        pressed = 1'b0;
        store_reset();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        rows.push_back(mkw(CMD_GET, 0, 0, 1'b1));
        rows.push_back(mkw(CMD_DELETE, 0, 0, 1'b0));
        rows.push_back(mkw(CMD_DELETE, 0, 3, 1'b1));
        rows.push_back(mk(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8, 1, 0, 0));
        rows.push_back(mk(CMD_GET, '0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 127, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'hFEDC_BA98_7654_3210, 0, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h5555_AAAA_5555_AAAA, 3, 1, 0, 0));
        rows.push_back(mk(CMD_GET, '0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h1, 0, 1, 0, 0));
        rows.push_back(mk(CMD_GET, '0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h2, 16, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h3, 16, 0, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h4, 16, 1, 0, 0));
        rows.push_back(mk(CMD_INSERT, 64'h5, 24, 0, 0, 0));
        rows.push_back(mk(CMD_GET, '0, 0, 0, 1, 0));
        rows.push_back(mk(CMD_GET, '0, 0, 0, 63, 0));
        rows.push_back(mk(bhs_cmd_t'(CMD_NONE), '1, 127, 1, 63, 127));
        rows.push_back(mk(CMD_DELETE, '0, 0, 0, 0, 1));
        rows.push_back(mk(CMD_GET, '0, 0, 0, 2, 0));
        rows.push_back(mk(CMD_DELETE, '0, 0, 0, 0, 64));
        rows.push_back(mkw(CMD_GET, 0, 0, 1'b1));
        foreach (rows[i]) send_item(rows[i]);

        for (int k = 0; k < 300; k++) begin
            if (k >= 150 && !pressed)
            begin
                pressed = 1'b1;
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 40);
                nb = (len > NBYT ? NBYT : len + 7) / 8;
                if (nb == 0) nb = 1;
                for (int c = 0; c < nb; c++) begin
                    r = mk(CMD_INSERT, {$urandom, $urandom}, len,
                           (c == nb - 1) ? 1'b1 : ($urandom_range(0, 15) == 0), 0, 0);
                    if ($urandom_range(0, 7) == 0) r.len = 7'($urandom);
                    if (c > 0) r.len = 7'($urandom);
                    send_item(r);
                    if (c > 0) k++;
                    if (r.clast) break;
                end
            end
            else if (pick < 8)
                send_item(mk(CMD_GET, {$urandom, $urandom}, $urandom, 1'($urandom),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 6), 0));
            else if (pick < 9)
                send_item(mk(CMD_DELETE, {$urandom, $urandom}, $urandom, 1'($urandom),
                             $urandom, ($urandom_range(0, 4) == 0)
                                       ? $urandom_range(0, 64) : $urandom_range(0, 2)));
            else
                send_item(mk(bhs_cmd_t'(CMD_NONE), {$urandom, $urandom}, $urandom,
                             1'($urandom), $urandom, $urandom));
        end
        s_tvalid <= 1'b0;

        wait_c = 0;
        while (replies_due.size() != 0 && wait_c < 100000) begin
            @(posedge clk);
            wait_c++;
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/bhs_pkg.sv
rtl/bhs_ctrl.sv
rtl/bhs_dp.sv
rtl/block_history_store.sv
verif/tb_block_history_store.sv
